FILE: rtl/ptb_pkg.sv
package ptb_pkg;

	localparam int SLOT_W    = 4;
	localparam int TIMEOUT_W = 32;
	localparam int MAX_ADDR  = 16;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_CHECK = 2'd1,
		REQ_ADD   = 2'd2,
		REQ_DEL   = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic                 tick;
		logic                 add;
		logic                 del;
		logic                 start;
		logic                 step;
		logic [SLOT_W-1:0]    slot;
		logic [TIMEOUT_W-1:0] timeout;
	} cell_ctrl_t;

endpackage

FILE: rtl/ptb_if.sv
interface ptb_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [3:0]  slot;
	logic [31:0] timeout_value;

	modport source (output valid, output req_type, output slot, output timeout_value,
		input ready);
	modport sink (input valid, input req_type, input slot, input timeout_value,
		output ready);
endinterface

interface ptb_rsp_if;
	logic       valid;
	logic       ready;
	logic       fired;
	logic [3:0] fired_slot;
	logic       last;

	modport source (output valid, output fired, output fired_slot, output last,
		input ready);
	modport sink (input valid, input fired, input fired_slot, input last,
		output ready);
endinterface

FILE: rtl/ptb_cell.sv
module ptb_cell #(
	parameter int COUNT_WIDTH = 32,
	parameter int IDX         = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ptb_pkg::cell_ctrl_t ctrl,
	input  logic                token_in,
	output logic                token_out,
	output logic                hit
);
	import ptb_pkg::*;

	logic                   active_q;
	logic                   token_q;
	logic [COUNT_WIDTH-1:0] period_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   addressed;
	logic                   expired;

	assign addressed = (IDX < MAX_ADDR) && (ctrl.slot == SLOT_W'(IDX));
	assign expired   = count_q >= period_q;
	assign hit       = token_q && active_q && expired;
	assign token_out = token_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			token_q  <= 1'b0;
		end else begin
			if (ctrl.start || ctrl.step) begin
				token_q <= token_in;
			end
			if (ctrl.add && addressed) begin
				active_q <= 1'b1;
			end else if (ctrl.del && addressed) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.add && addressed) begin
			period_q <= COUNT_WIDTH'(ctrl.timeout);
			count_q  <= '0;
		end else if (ctrl.step && hit) begin
			count_q <= '0;
		end else if (ctrl.tick && active_q && (count_q != period_q)) begin
			count_q <= count_q + 1'b1;
		end
	end

endmodule

FILE: rtl/periodic_timer_bank.sv
// A bank of periodic timers held in a row of slot cells. Tick, add and delete
// transactions complete in the cycle they are accepted and produce no result.
// A check passes a scan token along the cells, one cell per cycle unless a
// held result waits on a stalled result sink, over the first min(NUM_SLOTS, 16)
// slots; each expired active slot yields one result in ascending slot order and
// its count restarts, and a check with nothing expired yields one empty result.
// No new request is accepted until a check has pushed its final result into the
// output register. Counts saturate at their period.
module periodic_timer_bank #(
	parameter int NUM_SLOTS   = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	ptb_req_if.sink   req,
	ptb_rsp_if.source rsp
);
	import ptb_pkg::*;

	localparam int ADDR_SLOTS = (NUM_SLOTS < MAX_ADDR) ? NUM_SLOTS : MAX_ADDR;
	localparam int IDX_W      = (ADDR_SLOTS > 1) ? $clog2(ADDR_SLOTS) : 1;

	state_t             state_q, state_d;
	cell_ctrl_t         ctrl;
	logic [NUM_SLOTS:0] token_chain;
	logic [NUM_SLOTS-1:0] hit_vec;
	logic               hit_any;
	logic               accept;
	logic               can_push;
	logic               push;
	logic               push_fired;
	logic [SLOT_W-1:0]  push_slot;
	logic               push_last;
	logic               scan_end;
	logic               pend_v_q;
	logic [SLOT_W-1:0]  pend_slot_q;
	logic [IDX_W-1:0]   idx_q;
	logic               out_valid_q;
	logic               fired_q;
	logic [SLOT_W-1:0]  fired_slot_q;
	logic               last_q;

	assign req.ready  = (state_q == ST_IDLE);
	assign accept     = req.valid && req.ready;
	assign can_push   = !out_valid_q || rsp.ready;
	assign hit_any    = |hit_vec;
	assign scan_end   = (idx_q == IDX_W'(ADDR_SLOTS - 1));

	assign rsp.valid      = out_valid_q;
	assign rsp.fired      = fired_q;
	assign rsp.fired_slot = fired_slot_q;
	assign rsp.last       = last_q;

	assign token_chain[0] = ctrl.start;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		logic token_to_cell;
		if (i < ADDR_SLOTS) begin : g_scan
			assign token_to_cell = token_chain[i];
		end else begin : g_noscan
			assign token_to_cell = 1'b0;
		end
		ptb_cell #(
			.COUNT_WIDTH (COUNT_WIDTH),
			.IDX         (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.token_in  (token_to_cell),
			.token_out (token_chain[i+1]),
			.hit       (hit_vec[i])
		);
	end

	always_comb begin
		state_d      = state_q;
		ctrl.tick    = 1'b0;
		ctrl.add     = 1'b0;
		ctrl.del     = 1'b0;
		ctrl.start   = 1'b0;
		ctrl.step    = 1'b0;
		ctrl.slot    = req.slot;
		ctrl.timeout = req.timeout_value;
		push         = 1'b0;
		push_fired   = pend_v_q;
		push_slot    = pend_slot_q;
		push_last    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_type_t'(req.req_type))
						REQ_TICK:  ctrl.tick = 1'b1;
						REQ_ADD:   ctrl.add  = 1'b1;
						REQ_DEL:   ctrl.del  = 1'b1;
						REQ_CHECK: begin
							ctrl.start = 1'b1;
							state_d    = ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (!(hit_any && pend_v_q) || can_push) begin
					ctrl.step = 1'b1;
					push      = hit_any && pend_v_q;
					if (scan_end) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				push_last = 1'b1;
				push_slot = pend_v_q ? pend_slot_q : '0;
				if (can_push) begin
					push    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_v_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.start) begin
				idx_q <= '0;
			end else if (ctrl.step && !scan_end) begin
				idx_q <= idx_q + 1'b1;
			end
			if (ctrl.step && hit_any) begin
				pend_v_q <= 1'b1;
			end else if (state_q == ST_FLUSH && can_push) begin
				pend_v_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step && hit_any) begin
			pend_slot_q <= SLOT_W'(idx_q);
		end
		if (push) begin
			fired_q      <= push_fired;
			fired_slot_q <= push_slot;
			last_q       <= push_last;
		end
	end

	// The scan token sits in at most one cell, and only while a scan runs.
	a_token_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(token_chain[NUM_SLOTS:1]))
		else $error("scan token duplicated");

	a_token_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(|token_chain[ADDR_SLOTS:1]) == (state_q == ST_SCAN))
		else $error("scan token out of step with the scan state");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("held result left over after a check");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> can_push)
		else $error("result overwrote an untaken transaction");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && can_push) |=> (out_valid_q && last_q))
		else $error("check ended without a final result");

endmodule

FILE: bench/timer_bank_checker.sv
module timer_bank_checker (
	input  logic clk,
	input  logic arst_n,
	ptb_req_if   req,
	ptb_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);
	import ptb_pkg::*;

	typedef struct packed {
		logic              fired;
		logic [SLOT_W-1:0] fired_slot;
		logic              last;
	} expiry_t;

	expiry_t              expiry_q[$];
	logic                 armed[MAX_ADDR];
	logic [TIMEOUT_W-1:0] period_r[MAX_ADDR];
	logic [TIMEOUT_W-1:0] ticks_r[MAX_ADDR];
	int                   fails;

	task automatic predict_request(input req_type_t kind, input logic [SLOT_W-1:0] s,
		input logic [TIMEOUT_W-1:0] tmo);
		logic [MAX_ADDR-1:0] hit;
		int                  top_hit;
		expiry_t             e;
		hit = '0;
		top_hit = -1;
		case (kind)
			REQ_TICK: begin
				for (int i = 0; i < MAX_ADDR; i++)
					if (armed[i] && ticks_r[i] != period_r[i])
						ticks_r[i] = ticks_r[i] + 1'b1;
			end
			REQ_ADD: begin
				armed[s] = 1'b1;
				period_r[s] = tmo;
				ticks_r[s] = '0;
			end
			REQ_DEL: begin
				armed[s] = 1'b0;
			end
			default: begin
				for (int i = 0; i < MAX_ADDR; i++) begin
					if (armed[i] && ticks_r[i] >= period_r[i]) begin
						ticks_r[i] = '0;
						hit[i] = 1'b1;
						top_hit = i;
					end
				end
				if (top_hit < 0) begin
					e.fired = 1'b0;
					e.fired_slot = '0;
					e.last = 1'b1;
					expiry_q.push_back(e);
				end else begin
					for (int i = 0; i < MAX_ADDR; i++) begin
						if (hit[i]) begin
							e.fired = 1'b1;
							e.fired_slot = i[SLOT_W-1:0];
							e.last = (i == top_hit);
							expiry_q.push_back(e);
						end
					end
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		expiry_t e;
		if (!arst_n) begin
			expiry_q.delete();
			for (int i = 0; i < MAX_ADDR; i++) begin
				armed[i] = 1'b0;
			end
			fails = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (req.valid && req.ready)
				predict_request(req_type_t'(req.req_type), req.slot, req.timeout_value);
			if (rsp.valid && rsp.ready) begin
				if (expiry_q.size() == 0) begin
					$error("unexpected result: fired %0d, fired_slot %0d, last %0d",
						rsp.fired, rsp.fired_slot, rsp.last);
					fails++;
				end else begin
					e = expiry_q.pop_front();
					if (rsp.fired !== e.fired) begin
						$error("fired: expected %0d, actual %0d", e.fired, rsp.fired);
						fails++;
					end
					if (rsp.fired_slot !== e.fired_slot) begin
						$error("fired_slot: expected %0d, actual %0d", e.fired_slot,
							rsp.fired_slot);
						fails++;
					end
					if (rsp.last !== e.last) begin
						$error("last: expected %0d, actual %0d", e.last, rsp.last);
						fails++;
					end
				end
			end
			fail_count <= fails;
			pending <= expiry_q.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
module tb_top;
	import ptb_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count = 0;
	bit   hold_req = 1'b0;
	bit   holding = 1'b0;

	ptb_req_if req ();
	ptb_rsp_if rsp ();

	periodic_timer_bank dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	timer_bank_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** periodic_timer_bank: FAILED **");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic logic [31:0] pick_period();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(4);
		if (r < 90)
			return $urandom_range(20, 5);
		return $urandom();
	endfunction

	task automatic send_req(input req_type_t kind, input logic [3:0] s,
		input logic [31:0] t, input bit gaps);
		int g;
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.slot <= s;
		req.timeout_value <= t;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic random_request();
		int          pick;
		logic [3:0]  s;
		logic [31:0] t;
		pick = $urandom_range(99);
		s = $urandom_range(15);
		t = pick_period();
		if (pick < 40)
			send_req(REQ_TICK, s, t, 1'b1);
		else if (pick < 65)
			send_req(REQ_CHECK, s, t, 1'b1);
		else if (pick < 90)
			send_req(REQ_ADD, s, t, 1'b1);
		else
			send_req(REQ_DEL, s, t, 1'b1);
	endtask

	// The result sink alternates ready and stall stretches, and on request
	// holds off for a long stretch so that a check backs up into the input.
	initial begin
		int lo;
		rsp.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				rsp.ready <= 1'b0;
				holding = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				holding = 1'b0;
			end
			rsp.ready <= 1'b1;
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(80, 40)) @(posedge clk);
			else
				repeat ($urandom_range(12, 1)) @(posedge clk);
			lo = gap_len();
			if (lo > 0) begin
				rsp.ready <= 1'b0;
				repeat (lo) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req.valid <= 1'b0;
		req.req_type <= REQ_TICK;
		req.slot <= '0;
		req.timeout_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_req(REQ_CHECK, 4'd0, 32'd0, 1'b1);
		send_req(REQ_ADD, 4'd0, 32'd0, 1'b1);
		send_req(REQ_CHECK, 4'd0, 32'd0, 1'b1);
		send_req(REQ_TICK, 4'd0, 32'd0, 1'b1);
		send_req(REQ_CHECK, 4'd0, 32'd0, 1'b1);
		send_req(REQ_ADD, 4'd15, 32'hFFFF_FFFF, 1'b1);
		send_req(REQ_ADD, 4'd3, 32'd2, 1'b1);
		repeat (3) send_req(REQ_TICK, 4'd5, 32'd0, 1'b1);
		send_req(REQ_CHECK, 4'd0, 32'd0, 1'b1);
		send_req(REQ_ADD, 4'd3, 32'd1, 1'b1);
		send_req(REQ_TICK, 4'd0, 32'd0, 1'b1);
		send_req(REQ_ADD, 4'd9, 32'h8000_0000, 1'b1);
		send_req(REQ_CHECK, 4'd0, 32'd0, 1'b1);
		send_req(REQ_DEL, 4'd7, 32'd0, 1'b1);
		send_req(REQ_DEL, 4'd0, 32'd0, 1'b1);
		send_req(REQ_TICK, 4'd0, 32'd0, 1'b1);
		send_req(REQ_CHECK, 4'd0, 32'd0, 1'b1);
		send_req(REQ_CHECK, 4'd0, 32'd0, 1'b1);
		send_req(REQ_DEL, 4'd3, 32'd0, 1'b1);
		send_req(REQ_DEL, 4'd15, 32'd0, 1'b1);
		send_req(REQ_DEL, 4'd9, 32'd0, 1'b1);
		send_req(REQ_CHECK, 4'd0, 32'd0, 1'b1);

		repeat (108) random_request();

		// Arm every slot, then issue tick and check pairs back to back while the sink is held off.
		req.valid <= 1'b0;
		hold_req = 1'b1;
		while (!holding)
			@(posedge clk);
		for (int i = 0; i < MAX_ADDR; i++)
			send_req(REQ_ADD, i[3:0], $urandom_range(1), 1'b0);
		repeat (3) begin
			send_req(REQ_TICK, 4'd0, 32'd0, 1'b0);
			send_req(REQ_CHECK, 4'd0, 32'd0, 1'b0);
		end
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);

		repeat (108) random_request();
		send_req(REQ_CHECK, 4'd0, 32'd0, 1'b0);
		req.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("** periodic_timer_bank: PASSED **");
		else
			$display("** periodic_timer_bank: FAILED **");
		$finish;
	end

endmodule
